### hdl/edge_gated_median_filter_assert.svh
// Assertion macros shared by the filter RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef EDGE_GATED_MEDIAN_FILTER_ASSERT_SVH
`define EDGE_GATED_MEDIAN_FILTER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define EGMF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define EGMF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EGMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/egmf_pkg.sv
`default_nettype none
package egmf_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 9;
  localparam int DIM_W      = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(32);
  localparam logic [DIM_W-1:0] WIDTH_RESET     = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET    = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_THRESHOLD = 2'd0,
    REG_LINE_WIDTH     = 2'd1,
    REG_FRAME_HEIGHT   = 2'd2
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  // Position information that travels with an item down the pipeline.
  typedef struct packed {
    logic has_result;
    logic interior;
    logic last;
  } pos_flags_t;

  // Low, middle and high value of one sorted window row.
  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } row_stats_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > lim) begin
      r = lim;
    end
    return r;
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage
`default_nettype wire

### hdl/edge_gated_median_filter.sv
// Edge-gated 3x3 median filter, one 8-bit plane in raster order.
// Throughput: one transaction per clock on each channel while the output is not
// stalled; the whole path is pipelined. A result in the output register belongs to
// the transaction completing its window (itself line_width+1 items after its pixel).
// Reset (rst, synchronous): clears counters, pipeline valids and window, loads the
// default registers; the line stores are not cleared and need no clearing pass.
`default_nettype none
`include "edge_gated_median_filter_assert.svh"

module edge_gated_median_filter (
  input  wire                             clk,
  input  wire                             rst,
  // Configuration write port.
  input  wire                             cfg_we,
  input  wire [egmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [egmf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input channel.
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             mode,
  input  wire [egmf_pkg::PIX_W-1:0]       pixel_in,
  // Output channel.
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [egmf_pkg::PIX_W-1:0]      pixel_out,
  output logic                            is_edge,
  output logic                            frame_last
);
  import egmf_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. The geometry is clamped once, when it is written,
  // so that the datapath only ever sees legal values.
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0] edge_threshold;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic             restart;

  assign restart = cfg_we && ((cfg_index == REG_LINE_WIDTH) ||
                              (cfg_index == REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THRESHOLD_RESET;
      w_eff          <= WIDTH_RESET;
      h_eff          <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[THR_W-1:0];
        REG_LINE_WIDTH:     w_eff <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
        REG_FRAME_HEIGHT:   h_eff <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The whole pipeline advances together unless the output
  // register holds a result that the sink is stalling. While the output is
  // free, a new transaction is taken in every cycle.
  // ---------------------------------------------------------------------------
  logic enable;
  logic in_accept;

  assign enable    = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Position counters. All of them are updated at the moment of acceptance, so
  // the end-of-frame restart is seen by the very next transaction. The result
  // position flags are computed here and travel down with the item.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] icol, icol_next;
  logic [DIM_W-1:0] irow, irow_next;
  logic [COL_W-1:0] ocol, ocol_next;
  logic [ROW_W-1:0] orow, orow_next;
  logic [DIM_W-1:0] pending, pending_next;

  logic [DIM_W-1:0] icol_inc;
  logic [DIM_W-1:0] ocol_inc;
  logic [DIM_W-1:0] orow_inc;
  logic             in_pixels;
  logic             row_wrap;
  pos_flags_t       acc_flags;
  pix_t             acc_pixel;

  always_comb begin
    icol_inc  = {1'b0, icol} + DIM_W'(1);
    ocol_inc  = {1'b0, ocol} + DIM_W'(1);
    orow_inc  = {1'b0, orow} + DIM_W'(1);
    in_pixels = irow < h_eff;
    row_wrap  = icol_inc >= w_eff;

    // A flush inside the frame is a zero pixel; anything past the frame too.
    acc_pixel = (mode || !in_pixels) ? '0 : pixel_in;

    acc_flags.has_result = pending >= (w_eff + DIM_W'(1));
    acc_flags.interior   = (orow != '0) && (orow_inc < h_eff) &&
                           (ocol != '0) && (ocol_inc < w_eff);
    acc_flags.last       = (orow_inc >= h_eff) && (ocol_inc >= w_eff);

    icol_next    = icol;
    irow_next    = irow;
    ocol_next    = ocol;
    orow_next    = orow;
    pending_next = pending;

    if (in_accept) begin
      if (row_wrap) begin
        icol_next = '0;
        if (irow != '1) begin
          irow_next = irow + DIM_W'(1);
        end
      end else begin
        icol_next = icol_inc[COL_W-1:0];
      end

      if (!acc_flags.has_result) begin
        pending_next = pending + DIM_W'(1);
      end else if (acc_flags.last) begin
        // Frame complete: the next transaction starts a new frame.
        icol_next    = '0;
        irow_next    = '0;
        ocol_next    = '0;
        orow_next    = '0;
        pending_next = '0;
      end else if (ocol_inc >= w_eff) begin
        ocol_next = '0;
        orow_next = orow_inc[ROW_W-1:0];
      end else begin
        ocol_next = ocol_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      icol    <= '0;
      irow    <= '0;
      ocol    <= '0;
      orow    <= '0;
      pending <= '0;
    end else begin
      icol    <= icol_next;
      irow    <= irow_next;
      ocol    <= ocol_next;
      orow    <= orow_next;
      pending <= pending_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: accepted item plus the two line-store reads at its column. The
  // stores are written back when the item leaves stage 1.
  // With a one-pixel line the next item reads the column being written in the
  // same cycle, so that case is forwarded from stage 1 itself.
  // ---------------------------------------------------------------------------
  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  pix_t             s1_pixel;
  pos_flags_t       s1_flags;
  pix_t             s1_top;
  pix_t             s1_mid;
  logic             s1_write;

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];

  assign s1_write = enable && s1_valid;

  always_ff @(posedge clk) begin
    if (s1_write) begin
      upper_mem[s1_col]  <= s1_mid;
      middle_mem[s1_col] <= s1_pixel;
    end
    if (in_accept) begin
      if (s1_write && (s1_col == icol)) begin
        s1_top <= s1_mid;
        s1_mid <= s1_pixel;
      end else begin
        s1_top <= upper_mem[icol];
        s1_mid <= middle_mem[icol];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (enable) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col   <= icol;
      s1_pixel <= acc_pixel;
      s1_flags <= acc_flags;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the 3x3 window. Every item shifts it by one column; only items
  // that complete a result mark it valid for the stages below.
  // ---------------------------------------------------------------------------
  pix_t       win [9];
  logic       w_valid;
  pos_flags_t w_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
      w_valid <= 1'b0;
    end else if (enable) begin
      w_valid <= s1_valid && s1_flags.has_result;
      if (s1_valid) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= s1_top;
        win[3] <= win[4];
        win[4] <= win[5];
        win[5] <= s1_mid;
        win[6] <= win[7];
        win[7] <= win[8];
        win[8] <= s1_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable && s1_valid) begin
      w_flags <= s1_flags;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: each window row is sorted, and the centre is compared against
  // its eight neighbours. The median of nine is then the median of the
  // largest low, the middle middle and the smallest high of the sorted rows.
  // ---------------------------------------------------------------------------
  logic       edge_hit;
  logic       a_valid;
  row_stats_t a_rows [3];
  pix_t       a_center;
  logic       a_edge;
  logic       a_interior;
  logic       a_last;

  always_comb begin
    pix_t diff;
    edge_hit = 1'b0;
    for (int i = 0; i < 9; i++) begin
      diff = (win[i] > win[4]) ? (win[i] - win[4]) : (win[4] - win[i]);
      if ((i != 4) && ({1'b0, diff} >= edge_threshold)) begin
        edge_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (enable) begin
      a_valid <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      for (int r = 0; r < 3; r++) begin
        a_rows[r].lo <= min3(win[3*r], win[3*r+1], win[3*r+2]);
        a_rows[r].md <= med3(win[3*r], win[3*r+1], win[3*r+2]);
        a_rows[r].hi <= max3(win[3*r], win[3*r+1], win[3*r+2]);
      end
      a_center   <= win[4];
      a_edge     <= edge_hit;
      a_interior <= w_flags.interior;
      a_last     <= w_flags.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: output register. Border pixels and edges pass through untouched.
  // ---------------------------------------------------------------------------
  pix_t median;

  assign median = med3(max3(a_rows[0].lo, a_rows[1].lo, a_rows[2].lo),
                       med3(a_rows[0].md, a_rows[1].md, a_rows[2].md),
                       min3(a_rows[0].hi, a_rows[1].hi, a_rows[2].hi));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enable) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      pixel_out  <= (a_interior && !a_edge) ? median : a_center;
      is_edge    <= a_interior && a_edge;
      frame_last <= a_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `EGMF_ASSERT_IMPLIES(a_stall_only_on_full_out, in_stall, out_valid && out_stall,
                       "input stalled without a blocked result")
  `EGMF_ASSERT_ALWAYS(a_icol_in_line, {1'b0, icol} < w_eff,
                      "input column beyond line width")
  `EGMF_ASSERT_ALWAYS(a_pending_bound, pending <= (w_eff + DIM_W'(1)),
                      "pending count overran")
  `EGMF_ASSERT_IMPLIES(a_last_not_edge, out_valid && frame_last, !is_edge,
                       "final pixel flagged as edge")
  `EGMF_ASSERT_NEXT(a_held_when_blocked, out_valid && out_stall, out_valid,
                    "result lost while stalled")

endmodule
`default_nettype wire

### sim/tb_edge_gated_median_filter.sv
`timescale 1ns / 100ps

// Self-checking bench for the edge-gated 3x3 median filter.
//
// An initial block builds raster frames into a queue of samples. A clocked driver
// feeds them to the input channel with random gaps. A clocked monitor checks every
// output transaction against a queue of predicted results. The monitor also watches
// input acceptance and runs a cycle-free software copy of the filter on every
// accepted transaction, so expectations are built in a fixed order.
module tb_edge_gated_median_filter;
  import egmf_pkg::*;

  // Meaning of the mode field of an input transaction.
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Cycles allowed after the last expected result for work that yields no result.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Long receiver hold-off, started once after this many accepted transactions.
  localparam int unsigned HOLD_AT     = 120;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 350;

  typedef struct packed {
    logic flush;
    pix_t value;
  } sample_t;

  typedef struct packed {
    pix_t pixel;
    logic edge_flag;
    logic last;
  } filtered_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we    = 1'b0;
  cfg_reg_t              cfg_index = REG_EDGE_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic in_valid = 1'b0;
  logic mode     = MODE_PIXEL;
  pix_t pixel_in = '0;
  logic in_stall;

  logic out_valid;
  logic out_stall = 1'b0;
  pix_t pixel_out;
  logic is_edge;
  logic frame_last;

  edge_gated_median_filter dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .is_edge    (is_edge),
    .frame_last (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Samples waiting to be sent, and filter results waiting to be seen.
  sample_t   raster_q[$];
  filtered_t smoothed_q[$];

  // Software copy of the filter: line buffers, 3x3 window, raster counters and the
  // configuration registers as the block holds them.
  pix_t        upper_line [MAX_WIDTH];
  pix_t        middle_line[MAX_WIDTH];
  pix_t        win[9];
  int unsigned in_col, in_row, out_col, out_row, pend_count;
  logic [THR_W-1:0] thr_reg;
  logic [DIM_W-1:0] width_reg, height_reg;

  // Run statistics.
  int unsigned fail_count       = 0;
  int unsigned results_checked  = 0;
  int unsigned edge_results     = 0;
  int unsigned smoothed_results = 0;
  int unsigned frames_done      = 0;
  int unsigned blocked_cycles   = 0;
  int unsigned items_taken      = 0;

  // Idle shaping shared by both sides. While calm is set no new idle gaps are picked.
  logic        calm = 1'b0;
  int unsigned calm_left = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  sample_t   next_sample;
  filtered_t want;

  // Geometry registers are clamped to 1..limit when they are used.
  function automatic int unsigned effective_size(input logic [DIM_W-1:0] d,
                                                 input int unsigned limit);
    if (d == '0) return 1;
    if (d > limit) return limit;
    return d;
  endfunction

  function automatic void restart_raster();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    pend_count = 0;
  endfunction

  function automatic void reset_filter_copy();
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    restart_raster();
    thr_reg = THRESHOLD_RESET;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
  endfunction

  // Median of the current window, found by sorting a copy of it.
  function automatic pix_t window_median();
    pix_t v[9];
    pix_t x;
    int   j;
    v = win;
    for (int i = 1; i < 9; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && v[j - 1] > x) begin
        v[j] = v[j - 1];
        j--;
      end
      v[j] = x;
    end
    return v[4];
  endfunction

  function automatic logic window_has_edge();
    int c;
    int d;
    c = win[4];
    for (int i = 0; i < 9; i++) begin
      d = int'(win[i]) - c;
      if (d < 0) d = -d;
      if (i != 4 && d >= int'(thr_reg)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the filter copy by one accepted transaction and queues the result
  // that it produces, if any.
  function automatic void push_sample(input logic flush, input pix_t value);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    pix_t        v;
    pix_t        top;
    pix_t        mid;
    filtered_t   res;
    w = effective_size(width_reg, MAX_WIDTH);
    h = effective_size(height_reg, MAX_HEIGHT);
    // Flushes inside the frame act as black pixels; anything past the frame is
    // treated as a flush.
    v = (flush == MODE_FLUSH || in_row >= h) ? pix_t'(0) : value;
    col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
    top = upper_line[col];
    mid = middle_line[col];
    upper_line[col] = mid;
    middle_line[col] = v;
    for (int r = 0; r < 3; r++) begin
      win[r * 3] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = v;

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      if (in_row < 13'h1FFF) in_row++;
    end

    // The first line_width+1 transactions of a frame only fill the window.
    if (pend_count < w + 1) begin
      pend_count++;
      return;
    end

    res.pixel = win[4];
    res.edge_flag = 1'b0;
    if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
      res.edge_flag = window_has_edge();
      if (!res.edge_flag) begin
        res.pixel = window_median();
        smoothed_results++;
      end else begin
        edge_results++;
      end
    end
    res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    smoothed_q.push_back(res);

    if (res.last) begin
      frames_done++;
      restart_raster();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  function automatic void queue_sample(input logic flush, input pix_t value);
    sample_t s;
    s.flush = flush;
    s.value = value;
    raster_q.push_back(s);
  endfunction

  // Pixel near a per-frame base level, with occasional outliers and extremes, so
  // that both edge and smooth pixels show up at moderate thresholds.
  function automatic pix_t pick_pixel(input int base, input int spread);
    int unsigned r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 8) return pix_t'($urandom_range(0, 255));
    if (r < 11) return pix_t'(0);
    if (r < 14) return pix_t'(255);
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return pix_t'(v);
  endfunction

  // Queues one frame of the current geometry followed by its flush tail. Besides
  // clean frames, some have flushes inside the pixels, some have pixels in the
  // flush tail, and some carry a few extra transactions into the next frame.
  function automatic int unsigned queue_frame(input int unsigned w, input int unsigned h);
    int unsigned kind;
    int unsigned holes_pct;
    int unsigned stray_pct;
    int unsigned extra;
    int          base;
    int          spread;
    int unsigned count;
    kind = $urandom_range(0, 9);
    holes_pct = (kind == 7) ? 15 : 0;
    stray_pct = (kind == 8) ? 40 : 0;
    extra = (kind == 9) ? $urandom_range(1, 5) : 0;
    base = $urandom_range(0, 255);
    spread = $urandom_range(0, 40);
    count = 0;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < holes_pct) begin
        queue_sample(MODE_FLUSH, pix_t'($urandom_range(0, 255)));
      end else begin
        queue_sample(MODE_PIXEL, pick_pixel(base, spread));
      end
      count++;
    end
    for (int unsigned i = 0; i < w + 1 + extra; i++) begin
      if ($urandom_range(0, 99) < stray_pct || i >= w + 1) begin
        queue_sample(MODE_PIXEL, pick_pixel(base, spread));
      end else begin
        queue_sample(MODE_FLUSH, pix_t'($urandom_range(0, 255)));
      end
      count++;
    end
    return count;
  endfunction

  function automatic int unsigned pick_threshold();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 1;
      2: return 255;
      3: return 256;
      4: return 511;
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  // Geometry for the random part stays small; zero exercises the lower clamp.
  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 80) return $urandom_range(1, 8);
    return $urandom_range(9, 24);
  endfunction

  // Registers are only written while the block is idle, so the filter copy is
  // updated right here rather than at the write edge.
  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_EDGE_THRESHOLD: thr_reg = THR_W'(value);
      REG_LINE_WIDTH: begin
        width_reg = DIM_W'(value);
        restart_raster();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = DIM_W'(value);
        restart_raster();
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Waits until every queued sample is taken and every result has come back, then
  // lets the pipeline run dry.
  task automatic settle();
    @(negedge clk);
    while (raster_q.size() != 0 || in_valid || smoothed_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Alternates busy stretches with random idling and calm stretches without any.
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // Driver: the payload only moves when the current transaction is taken or none
  // is offered, so a stalled transaction stays put.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (raster_q.size() != 0) begin
        next_sample = raster_q.pop_front();
        in_valid <= 1'b1;
        mode <= next_sample.flush;
        pixel_in <= next_sample.value;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering, which must fill
  // the pipeline and push back on the input channel.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks the output transaction first, then feeds the accepted input
  // transaction to the filter copy, so the order never depends on the scheduler.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (smoothed_q.size() == 0) begin
          $error("result with nothing expected: pixel_out %0d is_edge %0b frame_last %0b",
                 pixel_out, is_edge, frame_last);
          fail_count++;
        end else begin
          want = smoothed_q.pop_front();
          results_checked++;
          if (pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, pixel_out);
            fail_count++;
          end
          if (is_edge !== want.edge_flag) begin
            $error("is_edge: expected %0b, got %0b", want.edge_flag, is_edge);
            fail_count++;
          end
          if (frame_last !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, frame_last);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        push_sample(mode, pixel_in);
        items_taken <= items_taken + 1;
      end
      if (in_valid && in_stall) blocked_cycles++;

      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned random_items;
    pix_t        frame_a[9];
    pix_t        frame_b[9];

    frame_a = '{8'd0, 8'd255, 8'd17, 8'd200, 8'd128, 8'd90, 8'd1, 8'd254, 8'd60};
    frame_b = '{8'd10, 8'd250, 8'd30, 8'd40, 8'd77, 8'd0, 8'd70, 8'd80, 8'd90};
    random_items = 0;
    reset_filter_copy();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: threshold zero on a 3x3 frame, so the single interior pixel is an
    // edge, with both pixel extremes in its window.
    write_reg(REG_EDGE_THRESHOLD, 0);
    write_reg(REG_LINE_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    foreach (frame_a[i]) queue_sample(MODE_PIXEL, frame_a[i]);
    repeat (4) queue_sample(MODE_FLUSH, 8'd255);
    settle();

    // Threshold above any difference: the centre is smoothed. The centre itself
    // arrives as a flush inside the frame, and the tail carries a stray pixel.
    write_reg(REG_EDGE_THRESHOLD, 256);
    foreach (frame_b[i]) queue_sample((i == 4) ? MODE_FLUSH : MODE_PIXEL, frame_b[i]);
    queue_sample(MODE_FLUSH, 8'd0);
    queue_sample(MODE_PIXEL, 8'd255);
    queue_sample(MODE_FLUSH, 8'd170);
    queue_sample(MODE_FLUSH, 8'd85);
    settle();

    // Zero geometry clamps to a single pixel frame.
    write_reg(REG_EDGE_THRESHOLD, 255);
    write_reg(REG_LINE_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    queue_sample(MODE_PIXEL, 8'd255);
    queue_sample(MODE_FLUSH, 8'd0);
    queue_sample(MODE_FLUSH, 8'd1);
    settle();

    // Oversized width clamps to the widest line, so a short burst stays within
    // the fill of the first line and yields no result.
    write_reg(REG_LINE_WIDTH, 8191);
    write_reg(REG_FRAME_HEIGHT, 2);
    repeat (40) queue_sample(MODE_PIXEL, pix_t'($urandom_range(0, 255)));
    settle();

    // Oversized height clamps to the tallest frame. On a one-pixel line this
    // burst stays inside the frame, and it carries the receiver hold-off.
    write_reg(REG_LINE_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 8191);
    repeat (160) queue_sample(MODE_PIXEL, pick_pixel(128, 40));
    settle();

    // Small geometry to start the random part from.
    write_reg(REG_LINE_WIDTH, 5);
    write_reg(REG_FRAME_HEIGHT, 4);

    // Random phases: new settings between phases, one to three frames in each.
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0) write_reg(REG_EDGE_THRESHOLD, pick_threshold());
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_LINE_WIDTH, pick_dim());
        write_reg(REG_FRAME_HEIGHT, pick_dim());
      end
      repeat ($urandom_range(1, 3)) begin
        random_items += queue_frame(effective_size(width_reg, MAX_WIDTH),
                                    effective_size(height_reg, MAX_HEIGHT));
      end
      settle();
    end

    $display("Covered %0d input transactions and %0d checked results in %0d frames.",
             items_taken, results_checked, frames_done);
    $display("Saw %0d edge pixels, %0d smoothed pixels, %0d cycles of input backpressure.",
             edge_results, smoothed_results, blocked_cycles);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run of this stimulus.
  initial begin
    #(50_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
